>>> hw/rtl/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types, constants and small helpers of the median-then-mean filter.
// ----------------------------------------------------------------------------
package mtm_pkg;

   localparam int CHANNELS    = 3;
   localparam int CH_W        = 8;
   localparam int PIX_W       = CHANNELS * CH_W;
   localparam int SIDE        = 3;
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 4096;
   localparam int ROW_W       = 13;
   localparam int WIDTH_W     = 10;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   // sum of nine bytes times this, shifted right, gives sum / 9
   localparam int RECIP       = 3641;
   localparam int RECIP_W     = 12;
   localparam int RECIP_SHIFT = 15;
   localparam int SUM_W       = 12;
   localparam int COLSUM_W    = 10;
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type col_type [SIDE];
   typedef col_type win_type [SIDE];

   typedef struct packed {
      logic tick;
      logic x_zero;
      logic row_one;
      logic use_pix;
   } stc_ctrl_type;

   function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                            input logic [CH_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

>>> hw/rtl/mtm_ram.sv
// ----------------------------------------------------------------------------
// mtm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/mtm_stencil.sv
// ----------------------------------------------------------------------------
// mtm_stencil
// Two line buffers and a 3x3 window with replicated borders for one filter
// stage; hands out the window around the pixel one line and column behind.
// ----------------------------------------------------------------------------
module mtm_stencil #(
   parameter int MAX_WIDTH = mtm_pkg::MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_x,
   input  mtm_pkg::stc_ctrl_type        cur,
   input  logic [$clog2(MAX_WIDTH)-1:0] cur_x,
   input  mtm_pkg::pix_type             pix_in,
   output mtm_pkg::win_type             win_out
);

   localparam int XW = $clog2(MAX_WIDTH);

   logic [2*mtm_pkg::PIX_W-1:0] rdata;
   logic [2*mtm_pkg::PIX_W-1:0] wdata;
   mtm_pkg::pix_type            up;
   mtm_pkg::pix_type            lo;
   mtm_pkg::pix_type            v;
   mtm_pkg::col_type            col;
   mtm_pkg::win_type            win_ff;
   mtm_pkg::win_type            win_out_ff;

   // each entry holds the upper line above the lower line
   mtm_ram #(
      .WIDTH(2 * mtm_pkg::PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_lines (
      .clock(clock),
      .we   (en && cur.tick),
      .waddr(cur_x),
      .wdata(wdata),
      .re   (en),
      .raddr(rd_x[XW-1:0]),
      .rdata(rdata)
   );

   always_comb begin
      up     = rdata[2*mtm_pkg::PIX_W-1:mtm_pkg::PIX_W];
      lo     = rdata[mtm_pkg::PIX_W-1:0];
      v      = cur.use_pix ? pix_in : lo;
      col[0] = cur.row_one ? lo : up;
      col[1] = lo;
      col[2] = v;
      wdata  = {lo, v};
   end

   always_ff @(posedge clock) begin
      if (en && cur.tick) begin
         if (cur.x_zero) begin
            // right border of the previous line, then refill from the left edge
            win_out_ff[0] <= win_ff[1];
            win_out_ff[1] <= win_ff[2];
            win_out_ff[2] <= win_ff[2];
            win_ff[0]     <= col;
            win_ff[1]     <= col;
            win_ff[2]     <= col;
         end else begin
            win_out_ff[0] <= win_ff[1];
            win_out_ff[1] <= win_ff[2];
            win_out_ff[2] <= col;
            win_ff[0]     <= win_ff[1];
            win_ff[1]     <= win_ff[2];
            win_ff[2]     <= col;
         end
      end
   end

   assign win_out = win_out_ff;

endmodule

>>> hw/rtl/median_then_mean_denoise_3x3.sv
// ----------------------------------------------------------------------------
// median_then_mean_denoise_3x3
// 3x3 median then 3x3 box mean per RGB channel, replicated borders.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and gives filtered pixels in
// raster order, one item per clock when the output side keeps up; input is
// held only while a result waits unaccepted. A pixel flows through eleven
// register stages (line-buffer read, window, three median stages, second
// line-buffer read and window, column sums, total, reciprocal multiply,
// output register). Results trail input by two lines and two pixels of the
// frame, so after the last pixel send 2*width+2 filler items to drain it;
// fillers inside a frame are bubbles. Frame size is latched on the first
// pixel of a frame. The line buffers need no clearing after reset.
module median_then_mean_denoise_3x3 #(
   parameter int MAX_WIDTH = mtm_pkg::MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mtm_pkg::CH_W-1:0]           req_red_in,
   input  logic [mtm_pkg::CH_W-1:0]           req_green_in,
   input  logic [mtm_pkg::CH_W-1:0]           req_blue_in,
   input  logic                               req_filler,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mtm_pkg::CH_W-1:0]           rsp_red_out,
   output logic [mtm_pkg::CH_W-1:0]           rsp_green_out,
   output logic [mtm_pkg::CH_W-1:0]           rsp_blue_out,
   output logic                               rsp_frame_last,
   input  logic                               csr_we,
   input  logic [mtm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mtm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = mtm_pkg::ROW_W;
   localparam int CW     = mtm_pkg::CH_W;
   localparam int CH     = mtm_pkg::CHANNELS;
   localparam int STAGES = 10;

   typedef struct packed {
      logic             valid;
      logic             tick1;
      logic [XW-1:0]    x1;
      logic             row1_one;
      logic             pix1;
      logic             emit1;
      logic             tick2;
      logic [XW-1:0]    x2;
      logic             row2_one;
      logic             pix2;
      logic             emit2;
      logic             last;
      mtm_pkg::pix_type pix;
   } tok_type;

   logic                       en;
   logic                       accept;
   logic [mtm_pkg::WIDTH_W-1:0] width_ff;
   logic [YW-1:0]              height_ff;
   logic                       busy_ff, busy_in;
   logic [XW-1:0]              wm1_ff, wm1_in;
   logic [YW-1:0]              h_ff, h_in;
   logic [XW-1:0]              ix_ff, ix_in, mx_ff, mx_in, ox_ff, ox_in;
   logic [YW-1:0]              iy_ff, iy_in, my_ff, my_in, oy_ff, oy_in;

   logic                       start, active, bubble, step;
   logic                       live1, emit1, range2, tick2, emit2, last;
   logic [XW-1:0]              e_wm1, e_ix, e_mx, e_ox, clamp_wm1;
   logic [YW-1:0]              e_h, e_iy, e_my, e_oy, clamp_h;
   logic [YW-1:0]              width_ext;
   tok_type                    tok_in;
   tok_type                    tok_ff [STAGES];

   mtm_pkg::win_type           win1, win2;
   mtm_pkg::stc_ctrl_type      cur1, cur2;
   logic [CW-1:0]              sa_ff [CH][3][3];
   logic [CW-1:0]              sb_ff [CH][3];
   mtm_pkg::pix_type           med_ff;
   logic [mtm_pkg::COLSUM_W-1:0] cs_ff [CH][3];
   logic [mtm_pkg::SUM_W-1:0]  sum_ff [CH];
   logic [mtm_pkg::PROD_W-1:0] prod_ff [CH];
   logic                       rsp_valid_ff, rsp_last_ff;
   mtm_pkg::pix_type           rsp_pix_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mtm_pkg::WIDTH_W'(512);
         height_ff <= YW'(512);
      end else if (csr_we) begin
         unique case (csr_index)
            mtm_pkg::CSR_IMAGE_WIDTH: width_ff <= csr_wdata[mtm_pkg::WIDTH_W-1:0];
            mtm_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[YW-1:0];
            default: ;
         endcase
      end
   end

   // frame bookkeeping: decides per item which stage steps and what comes out
   always_comb begin
      width_ext = YW'(width_ff);
      if (width_ext < YW'(3)) begin
         clamp_wm1 = XW'(2);
      end else if (width_ext > YW'(MAX_WIDTH)) begin
         clamp_wm1 = XW'(MAX_WIDTH - 1);
      end else begin
         clamp_wm1 = XW'(width_ext - YW'(1));
      end
      if (height_ff < YW'(3)) begin
         clamp_h = YW'(3);
      end else if (height_ff > YW'(mtm_pkg::MAX_HEIGHT)) begin
         clamp_h = YW'(mtm_pkg::MAX_HEIGHT);
      end else begin
         clamp_h = height_ff;
      end

      start  = !busy_ff && !req_filler;
      active = busy_ff || start;
      e_wm1  = start ? clamp_wm1 : wm1_ff;
      e_h    = start ? clamp_h : h_ff;
      e_ix   = start ? '0 : ix_ff;
      e_iy   = start ? '0 : iy_ff;
      e_mx   = start ? '0 : mx_ff;
      e_my   = start ? '0 : my_ff;
      e_ox   = start ? '0 : ox_ff;
      e_oy   = start ? '0 : oy_ff;

      bubble = (e_iy < e_h) && req_filler;
      step   = accept && active && !bubble;
      live1  = (e_iy <= e_h) || ((e_iy == e_h + YW'(1)) && (e_ix == '0));
      emit1  = live1 && ((e_ix == '0) ? (e_iy >= YW'(2)) : (e_iy >= YW'(1)));
      range2 = (e_my <= e_h) || ((e_my == e_h + YW'(1)) && (e_mx == '0));
      tick2  = (emit1 || !live1) && range2;
      emit2  = tick2 && ((e_mx == '0) ? (e_my >= YW'(2)) : (e_my >= YW'(1)));
      last   = emit2 && (e_oy == e_h - YW'(1)) && (e_ox == e_wm1);

      busy_in = busy_ff;
      wm1_in  = wm1_ff;
      h_in    = h_ff;
      ix_in   = ix_ff;
      iy_in   = iy_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      if (step) begin
         busy_in = !last;
         wm1_in  = e_wm1;
         h_in    = e_h;
         ix_in   = e_ix;
         iy_in   = e_iy;
         mx_in   = e_mx;
         my_in   = e_my;
         ox_in   = e_ox;
         oy_in   = e_oy;
         if (live1) begin
            ix_in = (e_ix == e_wm1) ? '0 : e_ix + XW'(1);
            iy_in = (e_ix == e_wm1) ? e_iy + YW'(1) : e_iy;
         end
         if (tick2) begin
            mx_in = (e_mx == e_wm1) ? '0 : e_mx + XW'(1);
            my_in = (e_mx == e_wm1) ? e_my + YW'(1) : e_my;
         end
         if (emit2) begin
            ox_in = (e_ox == e_wm1) ? '0 : e_ox + XW'(1);
            oy_in = (e_ox == e_wm1) ? e_oy + YW'(1) : e_oy;
         end
      end

      tok_in.valid    = step;
      tok_in.tick1    = live1;
      tok_in.x1       = e_ix;
      tok_in.row1_one = (e_iy == YW'(1));
      tok_in.pix1     = (e_iy < e_h);
      tok_in.emit1    = emit1;
      tok_in.tick2    = tick2;
      tok_in.x2       = e_mx;
      tok_in.row2_one = (e_my == YW'(1));
      tok_in.pix2     = emit1 && (e_my < e_h);
      tok_in.emit2    = emit2;
      tok_in.last     = last;
      tok_in.pix      = {req_blue_in, req_green_in, req_red_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (en) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wm1_ff <= wm1_in;
         h_ff   <= h_in;
         ix_ff  <= ix_in;
         iy_ff  <= iy_in;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
      end
   end

   // item control travels alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            tok_ff[s] <= '0;
         end
      end else if (en) begin
         tok_ff[0] <= tok_in;
         for (int s = 1; s < STAGES; s++) begin
            tok_ff[s] <= tok_ff[s-1];
         end
      end
   end

   // median and mean stage window controls
   always_comb begin
      cur1.tick    = tok_ff[1].valid && tok_ff[1].tick1;
      cur1.x_zero  = (tok_ff[1].x1 == '0);
      cur1.row_one = tok_ff[1].row1_one;
      cur1.use_pix = tok_ff[1].pix1;
      cur2.tick    = tok_ff[5].valid && tok_ff[5].tick2;
      cur2.x_zero  = (tok_ff[5].x2 == '0);
      cur2.row_one = tok_ff[5].row2_one;
      cur2.use_pix = tok_ff[5].pix2;
   end

   mtm_stencil #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_median_win (
      .clock  (clock),
      .en     (en),
      .rd_x   (tok_ff[0].x1),
      .cur    (cur1),
      .cur_x  (tok_ff[1].x1),
      .pix_in (tok_ff[1].pix),
      .win_out(win1)
   );

   // median of nine: sort columns, then max of mins, median of mids, min of maxes
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < CH; c++) begin
            for (int k = 0; k < 3; k++) begin
               sa_ff[c][k][0] <= mtm_pkg::min2(mtm_pkg::min2(win1[k][0][c*CW +: CW],
                                 win1[k][1][c*CW +: CW]), win1[k][2][c*CW +: CW]);
               sa_ff[c][k][1] <= mtm_pkg::med3(win1[k][0][c*CW +: CW],
                                 win1[k][1][c*CW +: CW], win1[k][2][c*CW +: CW]);
               sa_ff[c][k][2] <= mtm_pkg::max2(mtm_pkg::max2(win1[k][0][c*CW +: CW],
                                 win1[k][1][c*CW +: CW]), win1[k][2][c*CW +: CW]);
            end
            sb_ff[c][0] <= mtm_pkg::max2(mtm_pkg::max2(sa_ff[c][0][0], sa_ff[c][1][0]),
                                         sa_ff[c][2][0]);
            sb_ff[c][1] <= mtm_pkg::med3(sa_ff[c][0][1], sa_ff[c][1][1], sa_ff[c][2][1]);
            sb_ff[c][2] <= mtm_pkg::min2(mtm_pkg::min2(sa_ff[c][0][2], sa_ff[c][1][2]),
                                         sa_ff[c][2][2]);
            med_ff[c*CW +: CW] <= mtm_pkg::med3(sb_ff[c][0], sb_ff[c][1], sb_ff[c][2]);
         end
      end
   end

   mtm_stencil #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_mean_win (
      .clock  (clock),
      .en     (en),
      .rd_x   (tok_ff[4].x2),
      .cur    (cur2),
      .cur_x  (tok_ff[5].x2),
      .pix_in (med_ff),
      .win_out(win2)
   );

   // box mean: column sums, total, then divide by nine via reciprocal
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < CH; c++) begin
            for (int k = 0; k < 3; k++) begin
               cs_ff[c][k] <= mtm_pkg::COLSUM_W'(win2[k][0][c*CW +: CW])
                            + mtm_pkg::COLSUM_W'(win2[k][1][c*CW +: CW])
                            + mtm_pkg::COLSUM_W'(win2[k][2][c*CW +: CW]);
            end
            sum_ff[c]  <= mtm_pkg::SUM_W'(cs_ff[c][0]) + mtm_pkg::SUM_W'(cs_ff[c][1])
                        + mtm_pkg::SUM_W'(cs_ff[c][2]);
            prod_ff[c] <= mtm_pkg::PROD_W'(sum_ff[c])
                        * mtm_pkg::PROD_W'(mtm_pkg::RECIP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tok_ff[9].valid && tok_ff[9].emit2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_last_ff <= tok_ff[9].last;
         for (int c = 0; c < CH; c++) begin
            rsp_pix_ff[c*CW +: CW] <= prod_ff[c][mtm_pkg::RECIP_SHIFT +: CW];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_pix_ff[0 +: CW];
   assign rsp_green_out  = rsp_pix_ff[CW +: CW];
   assign rsp_blue_out   = rsp_pix_ff[2*CW +: CW];
   assign rsp_frame_last = rsp_last_ff;

endmodule

>>> hw/rtl/mtm_checker.sv
// ----------------------------------------------------------------------------
// mtm_checker
// Port-level checks of the denoise filter's flow control over time.
// ----------------------------------------------------------------------------
module mtm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [mtm_pkg::CH_W-1:0] rsp_red_out,
   input logic [mtm_pkg::CH_W-1:0] rsp_green_out,
   input logic [mtm_pkg::CH_W-1:0] rsp_blue_out,
   input logic                     rsp_frame_last
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_last))
      else $error("stalled result changed");

   // input is only held back by an unaccepted result
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a result being taken never blocks the input
   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled while result taken");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind median_then_mean_denoise_3x3 mtm_checker u_mtm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_frame_last(rsp_frame_last)
);
